[rtl/core/assert_macros.svh]
// Assertion macros used by the engine RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, disabled in reset
`define ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

[rtl/core/lcbe_pkg.sv]
// Package: widths, opcodes and micro-op table for the Lucas-chain engine
`default_nettype none
package lcbe_pkg;
   localparam int RESIDUE_BITS_DEF = 64;
   localparam int FIELD_BITS = 64;
   localparam int CODE_BITS = 8;

   localparam logic [7:0] OP_SWAP = 8'h73;
   localparam logic [7:0] OP_INIT = 8'h69;
   localparam logic [7:0] OP_SUBF = 8'h66;
   localparam logic [7:0] OP_FIN  = 8'h46;

   // numbered PRAC rules
   localparam logic [7:0] OP_R1  = 8'd1;
   localparam logic [7:0] OP_R2  = 8'd2;
   localparam logic [7:0] OP_R3  = 8'd3;
   localparam logic [7:0] OP_R4  = 8'd4;
   localparam logic [7:0] OP_R5  = 8'd5;
   localparam logic [7:0] OP_R6  = 8'd6;
   localparam logic [7:0] OP_R7  = 8'd7;
   localparam logic [7:0] OP_R8  = 8'd8;
   localparam logic [7:0] OP_R9  = 8'd9;
   localparam logic [7:0] OP_R10 = 8'd10;
   localparam logic [7:0] OP_R11 = 8'd11;
   localparam logic [7:0] OP_R12 = 8'd12;
   localparam logic [7:0] OP_R13 = 8'd13;

   // micro-op: dst = src_a*src_b - src_d; register codes 0..4, 5 = constant two
   localparam logic [2:0] SEL_TWO = 3'd5;

   typedef struct packed {
      logic       mul;     // 1 = multiply step, 0 = copy step
      logic [2:0] dst;
      logic [2:0] a;
      logic [2:0] b;
      logic [2:0] d;
      logic       last;
   } uop_type;

   typedef struct packed {
      logic start;
      logic [63:0] ma;
      logic [63:0] mb;
   } mul_req_type;

   function automatic uop_type mk(input int m, input int dst, input int a,
                                  input int b, input int d, input int l);
      uop_type u;
      u.mul = 1'(m); u.dst = 3'(dst); u.a = 3'(a); u.b = 3'(b); u.d = 3'(d);
      u.last = 1'(l);
      return u;
   endfunction

   // copy step: dst = a ; swap uses register 3 as scratch when allowed
   function automatic uop_type uop_rom(input logic [7:0] op, input logic [2:0] s);
      uop_type u;
      u = mk(0, 0, 0, 0, 0, 1);
      case (op)
         OP_SWAP: case (s)
            3'd0: u = mk(0, 3, 0, 0, 0, 0);
            3'd1: u = mk(0, 0, 1, 0, 0, 0);
            default: u = mk(0, 1, 3, 0, 0, 1);
         endcase
         OP_INIT: case (s)
            3'd0: u = mk(0, 1, 0, 0, 0, 0);
            3'd1: u = mk(0, 2, 0, 0, 0, 0);
            default: u = mk(1, 0, 0, 0, 5, 1);
         endcase
         OP_SUBF: u = mk(1, 0, 0, 1, 2, 1);
         OP_FIN:  u = mk(1, 1, 0, 1, 2, 1);
         OP_R1: case (s)
            3'd0: u = mk(1, 3, 0, 1, 2, 0);
            3'd1: u = mk(1, 4, 3, 0, 1, 0);
            3'd2: u = mk(1, 1, 1, 3, 0, 0);
            default: u = mk(0, 0, 4, 0, 0, 1);
         endcase
         OP_R2: case (s)
            3'd0: u = mk(1, 1, 0, 1, 2, 0);
            default: u = mk(1, 0, 0, 0, 5, 1);
         endcase
         OP_R3: case (s)
            3'd0: u = mk(1, 3, 1, 0, 2, 0);
            3'd1: u = mk(0, 2, 1, 0, 0, 0);
            default: u = mk(0, 1, 3, 0, 0, 1);
         endcase
         OP_R4: case (s)
            3'd0: u = mk(1, 1, 1, 0, 2, 0);
            default: u = mk(1, 0, 0, 0, 5, 1);
         endcase
         OP_R5: case (s)
            3'd0: u = mk(1, 2, 2, 0, 1, 0);
            default: u = mk(1, 0, 0, 0, 5, 1);
         endcase
         // r3=dbl r0; r4=r0*r1-r2; r2=r3*r4-r2; r4=r3*r0-r0; r0<-r4; swap r1,r2
         OP_R6: case (s)
            3'd0: u = mk(1, 3, 0, 0, 5, 0);
            3'd1: u = mk(1, 4, 0, 1, 2, 0);
            3'd2: u = mk(1, 2, 3, 4, 2, 0);
            3'd3: u = mk(1, 4, 3, 0, 0, 0);
            3'd4: u = mk(0, 0, 4, 0, 0, 0);
            3'd5: u = mk(0, 4, 1, 0, 0, 0);
            3'd6: u = mk(0, 1, 2, 0, 0, 0);
            default: u = mk(0, 2, 4, 0, 0, 1);
         endcase
         OP_R7: case (s)
            3'd0: u = mk(1, 3, 0, 1, 2, 0);
            3'd1: u = mk(1, 1, 3, 0, 1, 0);
            3'd2: u = mk(1, 3, 0, 0, 5, 0);
            3'd3: u = mk(0, 4, 0, 0, 0, 0);
            default: u = mk(1, 0, 0, 3, 4, 1);
         endcase
         OP_R8: case (s)
            3'd0: u = mk(1, 3, 0, 1, 2, 0);
            3'd1: u = mk(1, 2, 2, 0, 1, 0);
            3'd2: u = mk(0, 1, 3, 0, 0, 0);
            3'd3: u = mk(1, 3, 0, 0, 5, 0);
            3'd4: u = mk(1, 4, 0, 3, 0, 0);
            default: u = mk(0, 0, 4, 0, 0, 1);
         endcase
         OP_R9: case (s)
            3'd0: u = mk(1, 2, 2, 1, 0, 0);
            default: u = mk(1, 1, 1, 1, 5, 1);
         endcase
         OP_R10: case (s)
            3'd0: u = mk(1, 1, 0, 1, 2, 0);
            3'd1: u = mk(0, 2, 1, 0, 0, 0);
            default: u = mk(1, 0, 1, 1, 5, 1);
         endcase
         OP_R11: case (s)
            3'd0: u = mk(0, 3, 0, 0, 0, 0);
            3'd1: u = mk(1, 0, 1, 0, 2, 0);
            3'd2: u = mk(0, 2, 1, 0, 0, 0);
            default: u = mk(0, 1, 3, 0, 0, 1);
         endcase
         OP_R12: case (s)
            3'd0: u = mk(1, 3, 1, 0, 2, 0);
            3'd1: u = mk(1, 2, 0, 3, 1, 0);
            3'd2: u = mk(0, 1, 2, 0, 0, 0);
            default: u = mk(1, 0, 2, 2, 5, 1);
         endcase
         OP_R13: case (s)
            3'd0: u = mk(0, 3, 1, 0, 0, 0);
            3'd1: u = mk(1, 1, 1, 0, 2, 0);
            3'd2: u = mk(0, 2, 0, 0, 0, 0);
            default: u = mk(1, 0, 0, 1, 3, 1);
         endcase
         default: u = mk(0, 0, 0, 0, 0, 1);
      endcase
      return u;
   endfunction

   function automatic logic known_op(input logic [7:0] op);
      return (op >= OP_R1 && op <= OP_R13) || op == OP_SWAP || op == OP_INIT
         || op == OP_SUBF || op == OP_FIN;
   endfunction
endpackage
`default_nettype wire

[rtl/core/lcbe_if.sv]
// Valid/ready channel interfaces for request and response beats
`default_nettype none
interface lcbe_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [63:0] start_value;
   logic [7:0]  code_byte;
   modport source (output valid, cmd, start_value, code_byte, input ready);
   modport sink (input valid, cmd, start_value, code_byte, output ready);
endinterface

interface lcbe_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] final_value;
   logic        bad_code;
   modport source (output valid, final_value, bad_code, input ready);
   modport sink (input valid, final_value, bad_code, output ready);
endinterface
`default_nettype wire

[rtl/core/lcbe_modunit.sv]
// Bit-serial modular unit: result = a*b - d mod m, one multiplier bit per cycle
`default_nettype none
module lcbe_modunit #(
   parameter int W = lcbe_pkg::RESIDUE_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] a,
   input  wire logic [W-1:0] b,
   input  wire logic [W-1:0] d,
   input  wire logic [W-1:0] m,
   output logic              done,
   output logic [W-1:0]      result
);
   localparam int CW = $clog2(W + 1);
   logic [W-1:0] acc_ff, acc_in, b_ff, b_in, a_ff, d_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [W:0] dbl, s1, s2;
   logic [W-1:0] acc1;

   always_comb begin
      dbl = {acc_ff, 1'b0};
      acc1 = (dbl >= {1'b0, m}) ? W'(dbl - {1'b0, m}) : W'(dbl);
      s1 = {1'b0, acc1} + {1'b0, a_ff};
      s2 = (s1 >= {1'b0, m}) ? s1 - {1'b0, m} : s1;
      busy_in = busy_ff; cnt_in = cnt_ff; acc_in = acc_ff; b_in = b_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1; cnt_in = CW'(W); acc_in = '0; b_in = b;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            // final subtract of d
            acc_in = (acc_ff >= d_ff) ? acc_ff - d_ff : W'(m - (d_ff - acc_ff));
            busy_in = 1'b0; done_in = 1'b1;
         end else begin
            acc_in = b_ff[W-1] ? W'(s2) : acc1;
            b_in = {b_ff[W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in; b_ff <= b_in;
      if (start) begin
         a_ff <= a; d_ff <= d;
      end
   end
   assign done = done_ff;
   assign result = acc_ff;
endmodule
`default_nettype wire

[rtl/core/lucas_chain_bytecode_engine.sv]
// Lucas-chain engine: an opcode runs 1..8 micro-steps.
// A start item is reduced serially into register 0; a code item first reduces all five
// registers serially, then runs its micro-steps (opcode 6 has the most); an unknown
// opcode is answered from idle with bad_code. W is RESIDUE_BITS clipped to 64. One item at a time.
// The result sits in an output register; a new item is taken once it is accepted.
// Reset (synchronous): modulus 3, registers zero, chain idle, no result pending.
`default_nettype none
`include "assert_macros.svh"
module lucas_chain_bytecode_engine #(
   parameter int RESIDUE_BITS = lcbe_pkg::RESIDUE_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  csr_we,
   input  wire logic [63:0] csr_wdata,
   lcbe_req_if.sink   req,
   lcbe_rsp_if.source rsp
);
   localparam int W = (RESIDUE_BITS > 64) ? 64 : RESIDUE_BITS;
   localparam logic [2:0] S_IDLE = 3'd0, S_RED = 3'd1, S_STEP = 3'd2,
                          S_WAIT = 3'd3, S_LOAD = 3'd4;

   logic [63:0] modulus_ff;
   logic [W-1:0] r_ff [5];
   logic [W-1:0] red_in;
   logic [2:0] state_ff, ridx_ff, step_ff;
   logic act_ff;
   logic [7:0] op_ff;
   logic [W-1:0] m_eff, two, opa, opb, opd, mres;
   logic mstart, mdone;
   logic rsp_v_ff, rsp_bad_ff;
   logic [63:0] rsp_val_ff;
   lcbe_pkg::uop_type u;

   assign m_eff = (modulus_ff[W-1:0] == '0) ? W'(1) : modulus_ff[W-1:0];
   // 2 mod m: zero for a modulus of one or two
   assign two = (m_eff <= W'(2)) ? '0 : W'(2);
   assign u = lcbe_pkg::uop_rom(op_ff, step_ff);

   function automatic logic [W-1:0] pick(input logic [2:0] s, input logic [W-1:0] rr [5],
                                         input logic [W-1:0] t);
      return (s == lcbe_pkg::SEL_TWO) ? t : rr[s];
   endfunction
   assign opa = pick(u.a, r_ff, two);
   assign opb = pick(u.b, r_ff, two);
   assign opd = pick(u.d, r_ff, two);
   assign mstart = (state_ff == S_STEP) && u.mul;

   // r mod m by one compare-subtract per cycle would be slow; values stay < 2^W,
   // and after any modulus write a register may exceed m, so a serial reducer runs
   lcbe_modunit #(.W(W)) u_mul (.clock, .reset, .start(mstart), .a(opa), .b(opb),
      .d(opd), .m(m_eff), .done(mdone), .result(mres));

   // serial reduction: x mod m via 1*x - 0, x shifted in from the top bit
   logic red_go;
   assign red_go = (state_ff == S_RED) || (state_ff == S_LOAD);
   assign red_in = '0;

   assign req.ready = (state_ff == S_IDLE) && !rsp_v_ff;
   assign rsp.valid = rsp_v_ff;
   assign rsp.final_value = rsp_val_ff;
   assign rsp.bad_code = rsp_bad_ff;

   logic red_busy_ff;
   logic [W-1:0] one_w;
   assign one_w = W'(1);
   logic rstart;
   assign rstart = red_go && !red_busy_ff;
   logic [W-1:0] rres;
   logic rdone;
   lcbe_modunit #(.W(W)) u_red (.clock, .reset, .start(rstart), .a(one_w),
      .b(r_ff[ridx_ff]), .d(red_in), .m(m_eff), .done(rdone), .result(rres));

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= 64'd3; state_ff <= S_IDLE; act_ff <= 1'b0;
         rsp_v_ff <= 1'b0; red_busy_ff <= 1'b0;
         for (int i = 0; i < 5; i++) r_ff[i] <= '0;
      end else begin
         if (csr_we) modulus_ff <= csr_wdata;
         if (rsp.valid && rsp.ready) rsp_v_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req.valid && req.ready) begin
               op_ff <= req.code_byte;
               if (!req.cmd) begin
                  for (int i = 1; i < 5; i++) r_ff[i] <= '0;
                  r_ff[0] <= req.start_value[W-1:0];
                  ridx_ff <= '0; act_ff <= 1'b1;
                  state_ff <= S_LOAD;
               end else if (act_ff) begin
                  if (!lcbe_pkg::known_op(req.code_byte)) begin
                     act_ff <= 1'b0; rsp_v_ff <= 1'b1;
                     rsp_val_ff <= '0; rsp_bad_ff <= 1'b1;
                  end else begin
                     ridx_ff <= '0; state_ff <= S_RED;
                  end
               end
            end
            S_LOAD: begin
               // reduce start value only
               if (!red_busy_ff) red_busy_ff <= 1'b1;
               else if (rdone) begin
                  r_ff[0] <= rres; red_busy_ff <= 1'b0; state_ff <= S_IDLE;
               end
            end
            S_RED: begin
               if (!red_busy_ff) red_busy_ff <= 1'b1;
               else if (rdone) begin
                  r_ff[ridx_ff] <= rres; red_busy_ff <= 1'b0;
                  if (ridx_ff == 3'd4) begin
                     step_ff <= '0; state_ff <= S_STEP;
                  end else ridx_ff <= ridx_ff + 3'd1;
               end
            end
            S_STEP: begin
               if (u.mul) state_ff <= S_WAIT;
               else begin
                  r_ff[u.dst] <= opa;
                  step_ff <= step_ff + 3'd1;
                  if (u.last) state_ff <= S_IDLE;
               end
            end
            S_WAIT: if (mdone) begin
               r_ff[u.dst] <= mres;
               step_ff <= step_ff + 3'd1;
               if (u.last) begin
                  state_ff <= S_IDLE;
                  if (op_ff == lcbe_pkg::OP_FIN) begin
                     act_ff <= 1'b0; rsp_v_ff <= 1'b1; rsp_bad_ff <= 1'b0;
                     rsp_val_ff <= 64'(mres);
                  end
               end else state_ff <= S_STEP;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // S_LOAD uses ridx 0 through the reducer
   `ASSERT_IMP(a_rdy_idle, clock, reset, req.ready, state_ff == S_IDLE)
   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid)
   `ASSERT_IMP(a_mul_wait, clock, reset, state_ff == S_WAIT, u.mul)
endmodule
`default_nettype wire

[bench/lcbe_tb_if.sv]
`timescale 1ns / 100ps
// Channel interfaces used by the bench are the RTL ones; this file holds the scoreboard class

typedef struct packed {
   logic [63:0] final_value;
   logic        bad_code;
} chain_result_type;

class chain_scoreboard;
   logic [63:0]   modulus_reg;
   logic [63:0]   regs [5];
   bit            active;
   chain_result_type expected_q[$];
   int            mismatches;

   function new();
      modulus_reg = 64'd3;
      foreach (regs[i]) regs[i] = '0;
      active = 0;
      mismatches = 0;
   endfunction

   function logic [63:0] eff_mod();
      return (modulus_reg == 0) ? 64'd1 : modulus_reg;
   endfunction

   function logic [63:0] mulm(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [127:0] p;
      p = 128'(a % m) * 128'(b % m);
      return 64'(p % 128'(m));
   endfunction

   function logic [63:0] subm(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      a = a % m;
      b = b % m;
      return a >= b ? a - b : m - (b - a);
   endfunction

   function logic [63:0] lucas_add(logic [63:0] a, logic [63:0] b, logic [63:0] d,
                                   logic [63:0] m);
      return subm(mulm(a, b, m), d, m);
   endfunction

   function logic [63:0] lucas_dbl(logic [63:0] a, logic [63:0] m);
      return subm(mulm(a, a, m), 64'd2 % m, m);
   endfunction

   // predicts one accepted request beat
   function void note_request(logic cmd, logic [63:0] sv, logic [7:0] op);
      logic [63:0] m, t;
      chain_result_type r;
      m = eff_mod();
      if (!cmd) begin
         foreach (regs[i]) regs[i] = '0;
         regs[0] = sv % m;
         active = 1;
         return;
      end
      if (!active) return;
      foreach (regs[i]) regs[i] = regs[i] % m;
      case (op)
         lcbe_pkg::OP_SWAP: begin
            t = regs[0]; regs[0] = regs[1]; regs[1] = t;
         end
         lcbe_pkg::OP_INIT: begin
            regs[1] = regs[0]; regs[2] = regs[0]; regs[0] = lucas_dbl(regs[0], m);
         end
         lcbe_pkg::OP_SUBF: regs[0] = lucas_add(regs[0], regs[1], regs[2], m);
         lcbe_pkg::OP_FIN: begin
            regs[1] = lucas_add(regs[0], regs[1], regs[2], m);
            active = 0;
            r.final_value = regs[1] % m;
            r.bad_code = 0;
            expected_q.push_back(r);
         end
         lcbe_pkg::OP_R1: begin
            regs[3] = lucas_add(regs[0], regs[1], regs[2], m);
            regs[4] = lucas_add(regs[3], regs[0], regs[1], m);
            regs[1] = lucas_add(regs[1], regs[3], regs[0], m);
            regs[0] = regs[4];
         end
         lcbe_pkg::OP_R2: begin
            regs[1] = lucas_add(regs[0], regs[1], regs[2], m);
            regs[0] = lucas_dbl(regs[0], m);
         end
         lcbe_pkg::OP_R3: begin
            regs[3] = lucas_add(regs[1], regs[0], regs[2], m);
            regs[2] = regs[1]; regs[1] = regs[3];
         end
         lcbe_pkg::OP_R4: begin
            regs[1] = lucas_add(regs[1], regs[0], regs[2], m);
            regs[0] = lucas_dbl(regs[0], m);
         end
         lcbe_pkg::OP_R5: begin
            regs[2] = lucas_add(regs[2], regs[0], regs[1], m);
            regs[0] = lucas_dbl(regs[0], m);
         end
         lcbe_pkg::OP_R6: begin
            regs[3] = lucas_dbl(regs[0], m);
            regs[4] = lucas_add(regs[0], regs[1], regs[2], m);
            regs[4] = lucas_add(regs[3], regs[4], regs[2], m);
            regs[2] = regs[4];
            regs[4] = lucas_add(regs[3], regs[0], regs[0], m);
            regs[0] = regs[4];
            t = regs[1]; regs[1] = regs[2]; regs[2] = t;
         end
         lcbe_pkg::OP_R7: begin
            regs[3] = lucas_add(regs[0], regs[1], regs[2], m);
            regs[4] = lucas_add(regs[3], regs[0], regs[1], m);
            regs[1] = regs[4];
            regs[3] = lucas_dbl(regs[0], m);
            regs[4] = regs[0];
            regs[0] = lucas_add(regs[0], regs[3], regs[4], m);
         end
         lcbe_pkg::OP_R8: begin
            regs[3] = lucas_add(regs[0], regs[1], regs[2], m);
            regs[2] = lucas_add(regs[2], regs[0], regs[1], m);
            regs[1] = regs[3];
            regs[3] = lucas_dbl(regs[0], m);
            regs[4] = lucas_add(regs[0], regs[3], regs[0], m);
            regs[0] = regs[4];
         end
         lcbe_pkg::OP_R9: begin
            regs[2] = lucas_add(regs[2], regs[1], regs[0], m);
            regs[1] = lucas_dbl(regs[1], m);
         end
         lcbe_pkg::OP_R10: begin
            regs[1] = lucas_add(regs[0], regs[1], regs[2], m);
            regs[2] = regs[1];
            regs[0] = lucas_dbl(regs[1], m);
         end
         lcbe_pkg::OP_R11: begin
            regs[3] = regs[0];
            regs[0] = lucas_add(regs[1], regs[0], regs[2], m);
            regs[2] = regs[1]; regs[1] = regs[3];
         end
         lcbe_pkg::OP_R12: begin
            regs[3] = lucas_add(regs[1], regs[0], regs[2], m);
            regs[2] = lucas_add(regs[0], regs[3], regs[1], m);
            regs[1] = regs[2];
            regs[0] = lucas_dbl(regs[2], m);
         end
         lcbe_pkg::OP_R13: begin
            regs[3] = regs[1];
            regs[1] = lucas_add(regs[1], regs[0], regs[2], m);
            regs[2] = regs[0];
            regs[0] = lucas_add(regs[0], regs[1], regs[3], m);
         end
         default: begin
            active = 0;
            r.final_value = '0;
            r.bad_code = 1;
            expected_q.push_back(r);
         end
      endcase
   endfunction

   function void check_result(logic [63:0] fv, logic bc);
      chain_result_type e;
      if (expected_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result beat: final_value=%h bad_code=%b", fv, bc);
         return;
      end
      e = expected_q.pop_front();
      if (e.final_value !== fv || e.bad_code !== bc) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result mismatch: expected %h/%b, got %h/%b",
                     e.final_value, e.bad_code, fv, bc);
      end
   endfunction
endclass

[bench/lucas_chain_bytecode_engine_tb.sv]
`timescale 1ns / 100ps
// Top-level bench for the Lucas-chain byte-code engine

module lucas_chain_bytecode_engine_tb;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int DRAIN_CYCLES = 1000;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [63:0] csr_wdata = '0;
   int          cycle_count = 0;
   bit          rsp_calm = 0;
   chain_scoreboard chain_sb = new();

   lcbe_req_if req ();
   lcbe_rsp_if rsp ();

   lucas_chain_bytecode_engine dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req(req.sink), .rsp(rsp.source)
   );

   always #4 clock = ~clock;

   initial begin
      req.valid = 0; req.cmd = 0; req.start_value = '0; req.code_byte = '0;
      rsp.ready = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // result side: random stalls except during the calm stretch
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         chain_sb.check_result(rsp.final_value, rsp.bad_code);
      rsp.ready <= reset ? 1'b0 : (rsp_calm || $urandom_range(99) >= 14);
   end

   // valid stays up after a beat; it drops on an idle cycle or in wait_drained
   task automatic send_beat(input logic cmd, input logic [63:0] sv, input logic [7:0] op,
                            input bit calm);
      while (!calm && $urandom_range(99) < 14) begin
         req.valid <= 0;
         @(posedge clock);
      end
      req.valid <= 1; req.cmd <= cmd; req.start_value <= sv; req.code_byte <= op;
      do @(posedge clock); while (!req.ready);
      chain_sb.note_request(cmd, sv, op);
   endtask

   task automatic wait_drained();
      req.valid <= 0;
      while (chain_sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_modulus(input logic [63:0] m);
      wait_drained();
      csr_we <= 1; csr_wdata <= m;
      @(posedge clock);
      csr_we <= 0;
      chain_sb.modulus_reg = m;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [7:0] valid_op();
      int k;
      k = $urandom_range(16);
      case (k)
         0: return lcbe_pkg::OP_SWAP;
         1: return lcbe_pkg::OP_INIT;
         2: return lcbe_pkg::OP_SUBF;
         3: return lcbe_pkg::OP_INIT;
         default: return 8'(k - 3);
      endcase
   endfunction

   // well-formed chain with random content, occasionally broken
   task automatic run_chain(input bit calm);
      int len;
      logic [7:0] op;
      send_beat(0, rand64(), '0, calm);
      send_beat(1, '0, lcbe_pkg::OP_INIT, calm);
      len = $urandom_range(6);
      repeat (len) begin
         op = ($urandom_range(99) < 4) ? 8'($urandom) : valid_op();
         send_beat(1, rand64(), op, calm);
      end
      if ($urandom_range(9) != 0) send_beat(1, rand64(), lcbe_pkg::OP_FIN, calm);
   endtask

   initial begin
      logic [63:0] mods [6];
      int items;
      mods[0] = 64'hFFFF_FFFF_FFFF_FFFF; mods[1] = 64'd3; mods[2] = 64'd0;
      mods[3] = 64'd1; mods[4] = 64'd1000; mods[5] = 64'hFFFF_FFFF_FFFF_FFC5;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: idle code, every opcode, unknown byte, restart, extremes
      send_beat(1, '0, lcbe_pkg::OP_FIN, 0);
      send_beat(0, 64'hFFFF_FFFF_FFFF_FFFF, '0, 0);
      send_beat(1, '0, lcbe_pkg::OP_INIT, 0);
      for (int op = 1; op <= 13; op++) send_beat(1, '0, 8'(op), 0);
      send_beat(1, '0, lcbe_pkg::OP_SWAP, 0);
      send_beat(1, '0, lcbe_pkg::OP_SUBF, 0);
      send_beat(1, '0, lcbe_pkg::OP_FIN, 0);
      send_beat(0, 64'd7, '0, 0);
      send_beat(0, 64'd5, '0, 0);
      send_beat(1, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 0);
      send_beat(1, '0, lcbe_pkg::OP_INIT, 0);
      send_beat(0, '0, '0, 0);
      send_beat(1, '0, 8'h00, 0);

      items = 25;
      for (int ph = 0; ph < 6; ph++) begin
         set_modulus(ph == 4 ? (rand64() | 64'd1) : mods[ph]);
         if (ph == 2) rsp_calm = 1;
         while (items < 175 * (ph + 1)) begin
            run_chain(ph == 2);
            items += 6;
            if ($urandom_range(19) == 0) begin
               wait_drained();
               set_modulus(mods[ph] == 0 ? 64'd0 : (rand64() | 64'd1));
               set_modulus(ph == 4 ? (rand64() | 64'd1) : mods[ph]);
            end
         end
         rsp_calm = 0;
      end
      // mid-chain modulus change without a final beat pending
      send_beat(0, rand64(), '0, 0);
      send_beat(1, '0, lcbe_pkg::OP_INIT, 0);
      set_modulus(64'd1_000_003);
      send_beat(1, '0, lcbe_pkg::OP_R2, 0);
      send_beat(1, '0, lcbe_pkg::OP_FIN, 0);

      wait_drained();
      if (chain_sb.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
